[hdl/sitoa_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
// Used by sitoa_ctrl, sitoa_dp and signed_int_to_decimal_ascii; depends on nothing.
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int QUOT_W     = 29;
    localparam int RECIP_SHIFT = 35;

    // ceil(2^35 / 10): exact quotient by ten for any 32-bit dividend.
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sub;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic neg;
        logic ptr_zero;
        logic out_free;
    } status_t;

endpackage

[hdl/sitoa_ctrl.sv]
// Sequencer for the converter: walks the divide-by-ten steps, then the emission.
// Depends on sitoa_pkg; drives sitoa_dp through cmd_t and reads its status_t.
module sitoa_ctrl
    import sitoa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub = 1'b1;
                if (!status.quot_zero)
                begin
                    state_next = ST_MUL;
                end
                else if (status.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.ptr_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/sitoa_dp.sv]
// Datapath: magnitude register, reciprocal divide by ten, digit buffer and
// output word register. Depends on sitoa_pkg; commanded by sitoa_ctrl.
module sitoa_dp
    import sitoa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAR_W-1:0]   character,
    output logic                last
);

    logic [VALUE_W-1:0]   mag_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [DIGIT_W-1:0]   digit_reg [MAX_DIGITS];
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot_times_ten;
    logic [DIGIT_W-1:0]   rem_digit;
    logic [VALUE_W-1:0]   abs_value;
    logic                 emit;

    assign abs_value = value[VALUE_W-1] ? (~value + 1'b1) : value;
    assign prod      = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};

    // The remainder is below ten, so its low four bits are enough.
    assign quot_times_ten = {quot_reg, 3'b000} + {2'b00, quot_reg, 1'b0};
    assign rem_digit      = mag_reg[DIGIT_W-1:0] - quot_times_ten[DIGIT_W-1:0];

    assign emit = cmd.emit_sign | cmd.emit_digit;

    assign status.quot_zero = (quot_reg == '0);
    assign status.neg       = neg_reg;
    assign status.ptr_zero  = (ptr_reg == '0);
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.sub)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                ptr_reg <= cnt_reg[IDX_W-1:0];
            end
            else if (cmd.emit_digit)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= abs_value;
            neg_reg <= value[VALUE_W-1];
        end
        else if (cmd.sub)
        begin
            mag_reg <= {{(VALUE_W-QUOT_W){1'b0}}, quot_reg};
        end

        if (cmd.mul)
        begin
            quot_reg <= prod[RECIP_SHIFT +: QUOT_W];
        end

        if (cmd.sub)
        begin
            digit_reg[cnt_reg[IDX_W-1:0]] <= rem_digit;
        end

        if (cmd.emit_sign)
        begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit_reg[ptr_reg]};
            last_reg <= (ptr_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    // The digit count never passes ten.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count out of range");

    // A digit step always leaves a decimal digit in the buffer.
    a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub |-> rem_digit <= DIGIT_W'(9))
        else $error("remainder is not a decimal digit");
`endif

endmodule

[hdl/signed_int_to_decimal_ascii.sv]
// Sequence: an accepted word is loaded, then each decimal digit takes a multiply by the
// reciprocal of ten and a remainder step, then the sign (if negative) and the digits go out.
// Characters go out one per cycle while out_stall allows; in_stall stays high until the
// last character is issued, so only one number is converted at a time.
// Reset: rst_n, asynchronous and active low, returns to idle with no word pending.
// Depends on sitoa_pkg, sitoa_ctrl and sitoa_dp.
module signed_int_to_decimal_ascii
    import sitoa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CHAR_W-1:0]  character,
    output logic               last
);

    cmd_t    cmd;
    status_t status;

    sitoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sitoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

`ifndef NO_ASSERTIONS
    // Once a word is taken, no other is taken until its last character is issued to the output register.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a conversion is running");

    // Every character shown is a minus sign or a decimal digit.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == ASCII_MINUS ||
                       (character >= ASCII_ZERO && character <= ASCII_NINE)))
        else $error("character is neither a sign nor a digit");

    // A minus sign is never the final character of a number.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == ASCII_MINUS) |-> !last)
        else $error("minus sign flagged as last");
`endif

endmodule
